// ===== design/hcd_pkg.sv =====
// Shared types, register codes and sizing constants of the hotkey click/hold detector.
package hcd_pkg;

    // Default and maximum number of hotkey slots.
    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_SLOTS     = 8;

    // Widths fixed by the register map and the payload fields.
    localparam int MASK_W   = 32;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 3;
    localparam int PRIO_W   = 4;
    localparam int ENTRY_W  = 6;
    localparam int PIN_W    = 5;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    // Walk: two priority steps, then one step per slot.
    localparam int PRIO_STEPS = 2;
    localparam int STEP_W     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PIN_TABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FLAGS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPECIAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PRIO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_PRIO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FN_MASK     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESH = 3'd6;

    // Reset values.
    localparam logic [PRIO_W-1:0] PRIO_NONE        = 4'd8;
    localparam logic [TIME_W-1:0] HOLD_THRESH_RST  = 32'd1000;

    typedef struct packed {
        logic [MASK_W-1:0] current_mask;
        logic [MASK_W-1:0] previous_mask;
        logic [TIME_W-1:0] now_ms;
    } hcd_in_t;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
    } hcd_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic              load_in;
        logic              step;
        logic [STEP_W-1:0] step_idx;
        logic              load_out;
    } hcd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic fire;
    } hcd_stat_t;

endpackage

// ===== design/hcd_ctrl.sv =====
// Controller state machine of the hotkey click/hold detector: step sequencing and output valid.
module hcd_ctrl #(
    parameter int NUM_SLOTS = hcd_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output hcd_pkg::hcd_cmd_t cmd,
    input  hcd_pkg::hcd_stat_t stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [hcd_pkg::STEP_W-1:0] LAST_STEP =
        hcd_pkg::STEP_W'(hcd_pkg::PRIO_STEPS + NUM_SLOTS - 1);

    logic [1:0]                 state_reg, state_next;
    logic [hcd_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.step_idx   = step_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.fire || step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/hcd_datapath.sv =====
// Datapath of the hotkey click/hold detector: config registers, slot state and per-step evaluation.
module hcd_datapath #(
    parameter int NUM_SLOTS = hcd_pkg::NUM_SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcd_pkg::CFG_W-1:0]          cfg_data,
    input  hcd_pkg::hcd_in_t                   in_data,
    output hcd_pkg::hcd_out_t                  out_data,
    input  hcd_pkg::hcd_cmd_t                  cmd,
    output hcd_pkg::hcd_stat_t                 stat
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [hcd_pkg::PRIO_W-1:0] SLOT_LIMIT = hcd_pkg::PRIO_W'(NUM_SLOTS);

    // Configuration registers.
    logic [hcd_pkg::CFG_W-1:0]     pin_table_reg;
    logic [hcd_pkg::MAX_SLOTS-1:0] hold_flags_reg;
    logic [hcd_pkg::MAX_SLOTS-1:0] special_reg;
    logic [hcd_pkg::PRIO_W-1:0]    first_prio_reg;
    logic [hcd_pkg::PRIO_W-1:0]    second_prio_reg;
    logic [hcd_pkg::MASK_W-1:0]    fn_mask_reg;
    logic [hcd_pkg::TIME_W-1:0]    hold_thresh_reg;

    // Captured request and per-slot state.
    hcd_pkg::hcd_in_t           req_reg;
    logic                       pressed_reg [NUM_SLOTS];
    logic                       done_reg    [NUM_SLOTS];
    logic [hcd_pkg::TIME_W-1:0] ptime_reg   [NUM_SLOTS];

    logic                       res_fired_reg;
    logic [hcd_pkg::SLOT_W-1:0] res_slot_reg;
    hcd_pkg::hcd_out_t          out_reg;

    // Step evaluation.
    logic [hcd_pkg::SLOT_W-1:0]  slot_sel;
    logic [IDX_W-1:0]            slot_idx;
    logic [hcd_pkg::STEP_W-1:0]  scan_pos;
    logic                        is_prio;
    logic                        step_ok;
    logic [hcd_pkg::ENTRY_W-1:0] entry;
    logic [hcd_pkg::MASK_W-1:0]  want;
    logic                        cur_dn, prev_dn;
    logic                        hold;
    logic                        pressed_cur, done_cur;
    logic [hcd_pkg::TIME_W-1:0]  ptime_cur;
    logic [hcd_pkg::TIME_W-1:0]  elapsed;
    logic                        pressed_next, done_next;
    logic [hcd_pkg::TIME_W-1:0]  ptime_next;
    logic                        fire;

    always_comb
    begin
        scan_pos = cmd.step_idx - hcd_pkg::STEP_W'(hcd_pkg::PRIO_STEPS);
        is_prio  = (cmd.step_idx < hcd_pkg::STEP_W'(hcd_pkg::PRIO_STEPS));
        if (cmd.step_idx == '0)
        begin
            slot_sel = first_prio_reg[hcd_pkg::SLOT_W-1:0];
            step_ok  = (first_prio_reg < SLOT_LIMIT);
        end
        else if (is_prio)
        begin
            slot_sel = second_prio_reg[hcd_pkg::SLOT_W-1:0];
            step_ok  = (second_prio_reg < SLOT_LIMIT);
        end
        else
        begin
            slot_sel = scan_pos[hcd_pkg::SLOT_W-1:0];
            step_ok  = 1'b1;
        end
        slot_idx = slot_sel[IDX_W-1:0];

        entry = pin_table_reg[hcd_pkg::ENTRY_W*slot_sel +: hcd_pkg::ENTRY_W];
        want  = (hcd_pkg::MASK_W'(1) << entry[hcd_pkg::PIN_W-1:0]) | fn_mask_reg;

        // Scan slots must be enabled and not reserved for priority use.
        if (!is_prio && (!entry[hcd_pkg::ENTRY_W-1] || special_reg[slot_sel]))
        begin
            step_ok = 1'b0;
        end

        if (is_prio)
        begin
            cur_dn  = entry[hcd_pkg::ENTRY_W-1] && ((req_reg.current_mask & want) == want);
            prev_dn = entry[hcd_pkg::ENTRY_W-1] && ((req_reg.previous_mask & want) == want);
        end
        else
        begin
            cur_dn  = entry[hcd_pkg::ENTRY_W-1] && (req_reg.current_mask == want);
            prev_dn = entry[hcd_pkg::ENTRY_W-1] && (req_reg.previous_mask == want);
        end

        hold        = hold_flags_reg[slot_sel];
        pressed_cur = pressed_reg[slot_idx];
        done_cur    = done_reg[slot_idx];
        ptime_cur   = ptime_reg[slot_idx];
        elapsed     = req_reg.now_ms - ptime_cur;

        pressed_next = pressed_cur;
        done_next    = done_cur;
        ptime_next   = ptime_cur;
        fire         = 1'b0;

        if (cur_dn && !prev_dn)
        begin
            pressed_next = 1'b1;
            done_next    = 1'b0;
            ptime_next   = req_reg.now_ms;
        end
        else if (!cur_dn && prev_dn)
        begin
            fire         = pressed_cur && !done_cur && !hold;
            pressed_next = 1'b0;
            done_next    = 1'b0;
            ptime_next   = '0;
        end
        else if (cur_dn && pressed_cur && !done_cur)
        begin
            if (hold && (elapsed >= hold_thresh_reg))
            begin
                done_next = 1'b1;
                fire      = 1'b1;
            end
        end

        stat.fire = cmd.step && step_ok && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_table_reg   <= '0;
            hold_flags_reg  <= '0;
            special_reg     <= '0;
            first_prio_reg  <= hcd_pkg::PRIO_NONE;
            second_prio_reg <= hcd_pkg::PRIO_NONE;
            fn_mask_reg     <= '0;
            hold_thresh_reg <= hcd_pkg::HOLD_THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hcd_pkg::REG_PIN_TABLE:   pin_table_reg   <= cfg_data;
                hcd_pkg::REG_HOLD_FLAGS:  hold_flags_reg  <= cfg_data[hcd_pkg::MAX_SLOTS-1:0];
                hcd_pkg::REG_SPECIAL:     special_reg     <= cfg_data[hcd_pkg::MAX_SLOTS-1:0];
                hcd_pkg::REG_FIRST_PRIO:  first_prio_reg  <= cfg_data[hcd_pkg::PRIO_W-1:0];
                hcd_pkg::REG_SECOND_PRIO: second_prio_reg <= cfg_data[hcd_pkg::PRIO_W-1:0];
                hcd_pkg::REG_FN_MASK:     fn_mask_reg     <= cfg_data[hcd_pkg::MASK_W-1:0];
                hcd_pkg::REG_HOLD_THRESH: hold_thresh_reg <= cfg_data[hcd_pkg::TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pressed_reg[i] <= 1'b0;
                done_reg[i]    <= 1'b0;
                ptime_reg[i]   <= '0;
            end
        end
        else if (cmd.step && step_ok)
        begin
            pressed_reg[slot_idx] <= pressed_next;
            done_reg[slot_idx]    <= done_next;
            ptime_reg[slot_idx]   <= ptime_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_fired_reg <= 1'b0;
            res_slot_reg  <= '0;
        end
        else if (cmd.load_in)
        begin
            res_fired_reg <= 1'b0;
            res_slot_reg  <= '0;
        end
        else if (stat.fire)
        begin
            res_fired_reg <= 1'b1;
            res_slot_reg  <= slot_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= in_data;
        end
        if (cmd.load_out)
        begin
            out_reg.fired      <= res_fired_reg;
            out_reg.fired_slot <= res_slot_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== design/fn_hotkey_click_hold_detector.sv =====
// Top level of the hotkey click and long-press detector.
//
// One request per scan tick carries the current and previous button masks and a
// millisecond timestamp; one response comes back per request, with fired set and the
// slot index when a hotkey triggered, or fired clear and slot 0 otherwise. The block
// walks the two priority slots (subset match on the masks) and then slots 0 to
// NUM_SLOTS-1 (exact match, enabled and non-special only), one slot per clock through a
// single evaluation unit, and stops at the first slot that fires. A request is captured
// at the accepting edge, walked slot by slot, and its result is then loaded into the
// output register once that register is free or its response is taken. The input stays
// stalled from accept until the output register is loaded. One request is in flight at
// a time; the next is accepted as soon as the response sits in the output register, even
// while that response is still stalled. Configuration writes go in through
// cfg_we/cfg_index/cfg_data and must only happen while no request is open.
module fn_hotkey_click_hold_detector #(
    parameter int NUM_SLOTS = hcd_pkg::NUM_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcd_pkg::CFG_W-1:0]     cfg_data,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hcd_pkg::hcd_in_t              in_data,
    // Response channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output hcd_pkg::hcd_out_t             out_data
);

    hcd_pkg::hcd_cmd_t  cmd;
    hcd_pkg::hcd_stat_t stat;

    // Sequence capture, walk and output load.
    hcd_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold config, per-slot press state and the single evaluation unit.
    hcd_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
